>>> rtl/rqcd_pkg.sv
// Shared types, constants and key function for the ready queue dispatcher.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps

package rqcd_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int MAX_CORES   = 32;
  localparam int KEY_BITS    = 16;

  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CORE_W     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int JOB_W      = 7;
  localparam int LEN_W      = 16;
  localparam int PRIO_W     = 6;
  localparam int POL_W      = 2;
  localparam int CCNT_W     = 6;
  localparam int ACT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [31:0] KEY_MAX32 = 32'((64'(1) << KEY_BITS) - 64'(1));

  localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
  localparam logic [POL_W-1:0] POL_PRIO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT = 1'b1;

  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DISP
  } state_t;

  // command broadcast to every queue cell
  typedef struct packed {
    logic                insert;
    logic                pop;
    logic                sorted;
    logic [KEY_BITS-1:0] key;
    logic [JOB_W-1:0]    job;
  } q_op_t;

  typedef struct packed {
    logic              free_en;
    logic [CORE_W-1:0] free_idx;
    logic              claim_en;
  } core_req_t;

  typedef struct packed {
    logic              avail;
    logic [CORE_W-1:0] idx;
  } core_stat_t;

  // Sort key: saturated length for SJF, sign-flipped priority for priority order,
  // zero for arrival order.
  function automatic logic [KEY_BITS-1:0] make_key(input logic [POL_W-1:0]  pol,
                                                   input logic [LEN_W-1:0]  len,
                                                   input logic [PRIO_W-1:0] prio);
    logic [KEY_BITS-1:0] key;
    logic [31:0]         len32;
    key   = '0;
    len32 = 32'(len);
    if (pol == POL_SJF) begin
      if (len32 > KEY_MAX32) begin
        key = KEY_BITS'(KEY_MAX32);
      end else begin
        key = KEY_BITS'(len32);
      end
    end else if (pol == POL_PRIO) begin
      key = KEY_BITS'({~prio[PRIO_W-1], prio[PRIO_W-2:0]});
    end
    return key;
  endfunction

endpackage

>>> rtl/rqcd_cell.sv
// One slot of the sorted ready queue: holds a job and its key, shifts
// right on insert and left on pop. Depends on rqcd_pkg.
`timescale 1ns / 1ps

module rqcd_cell (
  input  logic                         clk,
  input  rqcd_pkg::q_op_t              op,
  input  logic                         occ,
  input  logic                         at_tail,
  input  logic                         gt_left,
  input  logic [rqcd_pkg::JOB_W-1:0]   left_job,
  input  logic [rqcd_pkg::KEY_BITS-1:0] left_key,
  input  logic [rqcd_pkg::JOB_W-1:0]   right_job,
  input  logic [rqcd_pkg::KEY_BITS-1:0] right_key,
  output logic [rqcd_pkg::JOB_W-1:0]   job,
  output logic [rqcd_pkg::KEY_BITS-1:0] key,
  output logic                         gt
);

  logic [rqcd_pkg::JOB_W-1:0]    job_r, job_nxt;
  logic [rqcd_pkg::KEY_BITS-1:0] key_r, key_nxt;

  // high from the first slot with a strictly greater key onward: the new job
  // goes in front of that slot and every slot behind it shifts right, even
  // when older entries are not in key order after a policy change
  assign gt  = gt_left | (op.sorted & occ & (key_r > op.key));
  assign job = job_r;
  assign key = key_r;

  always_comb begin
    job_nxt = job_r;
    key_nxt = key_r;
    priority if (op.pop) begin
      job_nxt = right_job;
      key_nxt = right_key;
    end else if (op.insert) begin
      if (gt_left) begin
        job_nxt = left_job;
        key_nxt = left_key;
      end else if (gt || at_tail) begin
        job_nxt = op.job;
        key_nxt = op.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    key_r <= key_nxt;
  end

endmodule

>>> rtl/rqcd_queue.sv
// Sorted ready queue: a row of rqcd_cell slots plus the fill count.
// Head sits in slot 0. Depends on rqcd_pkg and rqcd_cell.
`timescale 1ns / 1ps

module rqcd_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rqcd_pkg::q_op_t             op,
  output logic [rqcd_pkg::JOB_W-1:0]  head_job,
  output logic [rqcd_pkg::CNT_W-1:0]  count
);

  logic [rqcd_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [rqcd_pkg::JOB_W-1:0]    job_q [rqcd_pkg::QUEUE_DEPTH];
  logic [rqcd_pkg::KEY_BITS-1:0] key_q [rqcd_pkg::QUEUE_DEPTH];
  logic                          gt_q  [rqcd_pkg::QUEUE_DEPTH];

  for (genvar i = 0; i < rqcd_pkg::QUEUE_DEPTH; i++) begin : g_cell
    logic                          gt_l;
    logic [rqcd_pkg::JOB_W-1:0]    job_l, job_rt;
    logic [rqcd_pkg::KEY_BITS-1:0] key_l, key_rt;

    if (i == 0) begin : g_first
      assign gt_l  = 1'b0;
      assign job_l = op.job;
      assign key_l = op.key;
    end else begin : g_mid
      assign gt_l  = gt_q[i-1];
      assign job_l = job_q[i-1];
      assign key_l = key_q[i-1];
    end

    if (i == rqcd_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign job_rt = job_q[i];
      assign key_rt = key_q[i];
    end else begin : g_inner
      assign job_rt = job_q[i+1];
      assign key_rt = key_q[i+1];
    end

    rqcd_cell u_cell (
      .clk       (clk),
      .op        (op),
      .occ       (count_r > rqcd_pkg::CNT_W'(i)),
      .at_tail   (count_r == rqcd_pkg::CNT_W'(i)),
      .gt_left   (gt_l),
      .left_job  (job_l),
      .left_key  (key_l),
      .right_job (job_rt),
      .right_key (key_rt),
      .job       (job_q[i]),
      .key       (key_q[i]),
      .gt        (gt_q[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    priority if (op.pop) begin
      count_nxt = count_r - rqcd_pkg::CNT_W'(1);
    end else if (op.insert) begin
      count_nxt = count_r + rqcd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_job = job_q[0];
  assign count    = count_r;

endmodule

>>> rtl/rqcd_cores.sv
// Core busy table and lowest-free-core search below the active core count.
// Depends on rqcd_pkg.
`timescale 1ns / 1ps

module rqcd_cores (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rqcd_pkg::CCNT_W-1:0] core_count,
  input  rqcd_pkg::core_req_t         req,
  output rqcd_pkg::core_stat_t        stat
);

  logic [rqcd_pkg::MAX_CORES-1:0] busy_r, busy_nxt;
  logic [rqcd_pkg::ACT_W-1:0]     act;
  logic                           free_ok;

  // 0 counts as 1, anything above the core total is clamped
  always_comb begin
    if (core_count == '0) begin
      act = rqcd_pkg::ACT_W'(1);
    end else if (rqcd_pkg::ACT_W'(core_count) > rqcd_pkg::ACT_W'(rqcd_pkg::MAX_CORES)) begin
      act = rqcd_pkg::ACT_W'(rqcd_pkg::MAX_CORES);
    end else begin
      act = rqcd_pkg::ACT_W'(core_count);
    end
  end

  always_comb begin
    stat.avail = 1'b0;
    stat.idx   = '0;
    for (int i = rqcd_pkg::MAX_CORES - 1; i >= 0; i--) begin
      if (!busy_r[i] && (rqcd_pkg::ACT_W'(i) < act)) begin
        stat.avail = 1'b1;
        stat.idx   = rqcd_pkg::CORE_W'(i);
      end
    end
  end

  assign free_ok = ({1'b0, req.free_idx} < (rqcd_pkg::CORE_W + 1)'(rqcd_pkg::MAX_CORES));

  always_comb begin
    busy_nxt = busy_r;
    if (req.free_en && free_ok) begin
      busy_nxt[req.free_idx] = 1'b0;
    end
    if (req.claim_en) begin
      busy_nxt[stat.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

endmodule

>>> rtl/ready_queue_core_dispatcher.sv
// Top level: event sequencer, config registers, result register.
// Each accepted event gets an execute step (insert into the cell row, free a core, or flag a
// drop when the queue is full), then, unless dropped, a dispatch step that pops the head and
// claims a core if it can and may take the next event; a stalled result port holds either.
// Reset: sequencer idle, queue count zero, all cores free, policy 0, core count 1.
// Queue slots are not cleared; only slots below the count are ever read.
`timescale 1ns / 1ps

module ready_queue_core_dispatcher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [rqcd_pkg::JOB_W-1:0]      in_job_id,
  input  logic [rqcd_pkg::LEN_W-1:0]      in_job_length,
  input  logic signed [rqcd_pkg::PRIO_W-1:0] in_job_priority,
  input  logic [rqcd_pkg::CORE_W-1:0]     in_core_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rqcd_pkg::CORE_W-1:0]     out_dispatch_core,
  output logic [rqcd_pkg::JOB_W-1:0]      out_dispatch_job,
  output logic                            out_dropped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rqcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rqcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  rqcd_pkg::state_t state_r, state_nxt;

  logic                          ev_mode_r;
  logic [rqcd_pkg::JOB_W-1:0]    ev_job_r;
  logic [rqcd_pkg::LEN_W-1:0]    ev_len_r;
  logic [rqcd_pkg::PRIO_W-1:0]   ev_prio_r;
  logic [rqcd_pkg::CORE_W-1:0]   ev_core_r;
  logic [rqcd_pkg::POL_W-1:0]    policy_r;
  logic [rqcd_pkg::CCNT_W-1:0]   core_count_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [rqcd_pkg::CORE_W-1:0]   out_core_r, out_core_nxt;
  logic [rqcd_pkg::JOB_W-1:0]    out_job_r, out_job_nxt;
  logic                          out_drop_r, out_drop_nxt;

  rqcd_pkg::q_op_t      q_op;
  rqcd_pkg::core_req_t  c_req;
  rqcd_pkg::core_stat_t c_stat;
  logic [rqcd_pkg::JOB_W-1:0] head_job;
  logic [rqcd_pkg::CNT_W-1:0] count;
  logic                       out_free, load_out, in_xfer, full;

  rqcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (q_op),
    .head_job (head_job),
    .count    (count)
  );

  rqcd_cores u_cores (
    .clk        (clk),
    .rst_n      (rst_n),
    .core_count (core_count_r),
    .req        (c_req),
    .stat       (c_stat)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign full      = (count == rqcd_pkg::CNT_W'(rqcd_pkg::QUEUE_DEPTH));
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    load_out     = 1'b0;
    out_core_nxt = out_core_r;
    out_job_nxt  = out_job_r;
    out_drop_nxt = out_drop_r;
    q_op.insert  = 1'b0;
    q_op.pop     = 1'b0;
    q_op.sorted  = (policy_r == rqcd_pkg::POL_SJF) || (policy_r == rqcd_pkg::POL_PRIO);
    q_op.key     = rqcd_pkg::make_key(policy_r, ev_len_r, ev_prio_r);
    q_op.job     = ev_job_r;
    c_req.free_en  = 1'b0;
    c_req.free_idx = ev_core_r;
    c_req.claim_en = 1'b0;

    unique case (state_r)
      rqcd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = rqcd_pkg::S_EXEC;
        end
      end
      rqcd_pkg::S_EXEC: begin
        if (ev_mode_r == rqcd_pkg::MODE_ARRIVE) begin
          if (full) begin
            if (out_free) begin
              load_out     = 1'b1;
              out_core_nxt = '0;
              out_job_nxt  = ev_job_r;
              out_drop_nxt = 1'b1;
              state_nxt    = rqcd_pkg::S_IDLE;
            end
          end else begin
            q_op.insert = 1'b1;
            state_nxt   = rqcd_pkg::S_DISP;
          end
        end else begin
          c_req.free_en = 1'b1;
          state_nxt     = rqcd_pkg::S_DISP;
        end
      end
      rqcd_pkg::S_DISP: begin
        if ((count != '0) && c_stat.avail) begin
          if (out_free) begin
            load_out       = 1'b1;
            out_core_nxt   = c_stat.idx;
            out_job_nxt    = head_job;
            out_drop_nxt   = 1'b0;
            q_op.pop       = 1'b1;
            c_req.claim_en = 1'b1;
            in_ready       = 1'b1;
            state_nxt      = in_valid ? rqcd_pkg::S_EXEC : rqcd_pkg::S_IDLE;
          end
        end else begin
          in_ready  = 1'b1;
          state_nxt = in_valid ? rqcd_pkg::S_EXEC : rqcd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rqcd_pkg::S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rqcd_pkg::S_IDLE;
      out_valid_r  <= 1'b0;
      policy_r     <= '0;
      core_count_r <= rqcd_pkg::CCNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rqcd_pkg::REG_POLICY:     policy_r     <= cfg_data[rqcd_pkg::POL_W-1:0];
          rqcd_pkg::REG_CORE_COUNT: core_count_r <= cfg_data[rqcd_pkg::CCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_mode_r <= in_mode;
      ev_job_r  <= in_job_id;
      ev_len_r  <= in_job_length;
      ev_prio_r <= in_job_priority;
      ev_core_r <= in_core_index;
    end
    out_core_r <= out_core_nxt;
    out_job_r  <= out_job_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_dispatch_core = out_core_r;
  assign out_dispatch_job  = out_job_r;
  assign out_dropped       = out_drop_r;

endmodule

>>> rtl/rqcd_checker.sv
// Port-level checks for the dispatcher, bound to the top level.
// Depends on rqcd_pkg and ready_queue_core_dispatcher.
`timescale 1ns / 1ps

module rqcd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rqcd_pkg::CORE_W-1:0] out_dispatch_core,
  input logic [rqcd_pkg::JOB_W-1:0]  out_dispatch_job,
  input logic                        out_dropped
);

  // held result must not change until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dispatch_core)
      && $stable(out_dispatch_job) && $stable(out_dropped))
    else $error("result changed while stalled");

  a_drop_core: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_dispatch_core == '0)
    else $error("drop result carries a core");

  // an accepted event always goes through the execute step, where no event is taken
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("event taken in back-to-back cycles");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ready_queue_core_dispatcher rqcd_checker u_rqcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_dispatch_core (out_dispatch_core),
  .out_dispatch_job  (out_dispatch_job),
  .out_dropped       (out_dropped)
);

>>> test/ready_queue_core_dispatcher_tb.sv
// Self-checking bench for ready_queue_core_dispatcher: directed event table, then random
// phases across policies and core counts, checked against an in-bench scheduler or typed rows.
// Depends on rtl/rqcd_pkg.sv and rtl/ready_queue_core_dispatcher.sv.
`timescale 1ns / 1ps

module ready_queue_core_dispatcher_tb;

  localparam int CYCLE_LIMIT = 200_000;

  localparam logic [rqcd_pkg::POL_W-1:0] POL_FCFS  = 2'd0;
  localparam logic [rqcd_pkg::POL_W-1:0] POL_SPARE = 2'd3;  // unused code, arrival order

  typedef enum logic { ROW_EVENT, ROW_WRITE } row_kind_t;

  typedef struct packed {
    logic [rqcd_pkg::CORE_W-1:0] core;
    logic [rqcd_pkg::JOB_W-1:0]  job;
    logic                        dropped;
  } dispatch_t;

  typedef struct {
    row_kind_t                          kind;
    logic                               mode;
    logic [rqcd_pkg::JOB_W-1:0]         job;
    logic [rqcd_pkg::LEN_W-1:0]         len;
    logic signed [rqcd_pkg::PRIO_W-1:0] prio;
    logic [rqcd_pkg::CORE_W-1:0]        core;
    bit                                 typed;    // expectation written into the row
    bit                                 has_res;
    dispatch_t                          res;
    logic [rqcd_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic [rqcd_pkg::CFG_DATA_W-1:0]    reg_val;
  } row_t;

  typedef struct {
    logic [rqcd_pkg::JOB_W-1:0]    job;
    logic [rqcd_pkg::KEY_BITS-1:0] key;
  } slot_t;

  typedef struct {
    logic [rqcd_pkg::POL_W-1:0]  pol;
    logic [rqcd_pkg::CCNT_W-1:0] cores;
    int                          items;
    int                          arrive_pct;
  } phase_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_mode = rqcd_pkg::MODE_ARRIVE;
  logic [rqcd_pkg::JOB_W-1:0]         in_job_id = '0;
  logic [rqcd_pkg::LEN_W-1:0]         in_job_length = '0;
  logic signed [rqcd_pkg::PRIO_W-1:0] in_job_priority = '0;
  logic [rqcd_pkg::CORE_W-1:0]        in_core_index = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [rqcd_pkg::CORE_W-1:0]        out_dispatch_core;
  logic [rqcd_pkg::JOB_W-1:0]         out_dispatch_job;
  logic                               out_dropped;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [rqcd_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [rqcd_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

  // typed expectation travelling with the payload of a directed row
  bit        row_typed = 1'b0;
  bit        row_has = 1'b0;
  dispatch_t row_res = '0;

  // scheduler state mirrored by the bench
  slot_t                       ready_q[$];
  bit                          core_busy[rqcd_pkg::MAX_CORES] = '{default: 1'b0};
  logic [rqcd_pkg::POL_W-1:0]  pol_r = POL_FCFS;
  logic [rqcd_pkg::CCNT_W-1:0] ccnt_r = rqcd_pkg::CCNT_W'(1);

  dispatch_t due_dispatches[$];
  int        mismatch_count = 0;
  int        cycle_cnt = 0;
  int        burst_left = 0;
  bit        in_held = 1'b0;
  int        rcv_tick = 0;
  int        rcv_style = 0;

  ready_queue_core_dispatcher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_job_id         (in_job_id),
    .in_job_length     (in_job_length),
    .in_job_priority   (in_job_priority),
    .in_core_index     (in_core_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_dispatch_core (out_dispatch_core),
    .out_dispatch_job  (out_dispatch_job),
    .out_dropped       (out_dropped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic int live_cores();
    int n;
    n = int'(ccnt_r);
    if (n < 1) n = 1;
    if (n > rqcd_pkg::MAX_CORES) n = rqcd_pkg::MAX_CORES;
    return n;
  endfunction

  // Applies one event to the mirrored scheduler; returns 1 when it yields a result.
  function automatic bit schedule_event(input logic mode,
                                        input logic [rqcd_pkg::JOB_W-1:0] job,
                                        input logic [rqcd_pkg::LEN_W-1:0] len,
                                        input logic signed [rqcd_pkg::PRIO_W-1:0] prio,
                                        input logic [rqcd_pkg::CORE_W-1:0] core,
                                        output dispatch_t res);
    slot_t slot;
    int    pos;
    int    n;
    int    c;
    res = '0;
    if (mode == rqcd_pkg::MODE_ARRIVE) begin
      if (ready_q.size() >= rqcd_pkg::QUEUE_DEPTH) begin
        res.job = job;
        res.dropped = 1'b1;
        return 1'b1;
      end
      slot.job = job;
      slot.key = '0;
      // length is no wider than the key, so it never saturates
      if (pol_r == rqcd_pkg::POL_SJF) begin
        slot.key = rqcd_pkg::KEY_BITS'(len);
      end else if (pol_r == rqcd_pkg::POL_PRIO) begin
        slot.key = rqcd_pkg::KEY_BITS'(int'(prio) + 32);
      end
      if (pol_r == rqcd_pkg::POL_SJF || pol_r == rqcd_pkg::POL_PRIO) begin
        pos = 0;
        while (pos < ready_q.size() && ready_q[pos].key <= slot.key) pos++;
        ready_q.insert(pos, slot);
      end else begin
        ready_q.push_back(slot);
      end
    end else begin
      core_busy[core] = 1'b0;
    end
    if (ready_q.size() == 0) return 1'b0;
    n = live_cores();
    c = 0;
    while (c < n && core_busy[c]) c++;
    if (c >= n) return 1'b0;
    core_busy[c] = 1'b1;
    slot = ready_q.pop_front();
    res.core = rqcd_pkg::CORE_W'(c);
    res.job = slot.job;
    return 1'b1;
  endfunction

  // checks results, tracks register writes, predicts accepted events
  always @(posedge clk) begin : monitor
    dispatch_t got;
    dispatch_t want;
    dispatch_t pred;
    bit        made;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.core = out_dispatch_core;
        got.job = out_dispatch_job;
        got.dropped = out_dropped;
        if (due_dispatches.size() == 0) begin
          report_mismatch($sformatf("unexpected result core %0d job %0d dropped %0b",
                                    got.core, got.job, got.dropped));
        end else begin
          want = due_dispatches.pop_front();
          if (got.core !== want.core)
            report_mismatch($sformatf("dispatch_core %0d, expected %0d", got.core, want.core));
          if (got.job !== want.job)
            report_mismatch($sformatf("dispatch_job %0d, expected %0d", got.job, want.job));
          if (got.dropped !== want.dropped)
            report_mismatch($sformatf("dropped %0b, expected %0b", got.dropped, want.dropped));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rqcd_pkg::REG_POLICY) pol_r = cfg_data[rqcd_pkg::POL_W-1:0];
        else if (cfg_index == rqcd_pkg::REG_CORE_COUNT) ccnt_r = cfg_data;
      end
      if (in_valid && in_ready) begin
        made = schedule_event(in_mode, in_job_id, in_job_length, in_job_priority,
                              in_core_index, pred);
        if (row_typed) begin
          made = row_has;
          pred = row_res;
        end
        if (made) due_dispatches.push_back(pred);
      end
    end
  end

  // result side: drives out_ready in one of four randomly chosen stall styles
  always @(posedge clk) begin
    rcv_tick++;
    if (rcv_tick % 64 == 0) rcv_style = $urandom_range(0, 3);
    case (rcv_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= rcv_tick[3];
    endcase
  end

  function automatic row_t ev(input logic mode, input int job, input int len, input int prio,
                              input int core);
    row_t r;
    r.kind = ROW_EVENT;
    r.mode = mode;
    r.job = rqcd_pkg::JOB_W'(job);
    r.len = rqcd_pkg::LEN_W'(len);
    r.prio = rqcd_pkg::PRIO_W'(prio);
    r.core = rqcd_pkg::CORE_W'(core);
    r.typed = 1'b0;
    r.has_res = 1'b0;
    r.res = '0;
    r.reg_idx = '0;
    r.reg_val = '0;
    return r;
  endfunction

  function automatic row_t ev_x(input logic mode, input int job, input int len, input int prio,
                                input int core, input bit has, input int xcore,
                                input int xjob);
    row_t r;
    r = ev(mode, job, len, prio, core);
    r.typed = 1'b1;
    r.has_res = has;
    r.res.core = rqcd_pkg::CORE_W'(xcore);
    r.res.job = rqcd_pkg::JOB_W'(xjob);
    r.res.dropped = 1'b0;
    return r;
  endfunction

  function automatic row_t wr(input logic [rqcd_pkg::CFG_IDX_W-1:0] idx, input int val);
    row_t r;
    r = ev(rqcd_pkg::MODE_ARRIVE, 0, 0, 0, 0);
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = rqcd_pkg::CFG_DATA_W'(val);
    return r;
  endfunction

  function automatic row_t random_event(input int arrive_pct, input int span);
    row_t r;
    r = ev(rqcd_pkg::MODE_ARRIVE, 0, 0, 0, 0);
    r.mode = ($urandom_range(0, 99) < arrive_pct) ? rqcd_pkg::MODE_ARRIVE
                                                  : rqcd_pkg::MODE_FINISH;
    r.job = rqcd_pkg::JOB_W'($urandom_range(0, 127));
    case ($urandom_range(0, 3))
      0: r.len = rqcd_pkg::LEN_W'($urandom_range(0, 7));  // dense ties
      1: r.len = $urandom_range(0, 1) ? '1 : '0;
      default: r.len = rqcd_pkg::LEN_W'($urandom_range(0, 65535));
    endcase
    r.prio = rqcd_pkg::PRIO_W'($urandom_range(0, 39) - 20);
    // mostly finish cores that can actually be busy
    if ($urandom_range(0, 99) < 85) r.core = rqcd_pkg::CORE_W'($urandom_range(0, span - 1));
    else r.core = rqcd_pkg::CORE_W'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic send_item(input row_t r);
    in_valid <= 1'b1;
    in_mode <= r.mode;
    in_job_id <= r.job;
    in_job_length <= r.len;
    in_job_priority <= r.prio;
    in_core_index <= r.core;
    row_typed <= r.typed;
    row_has <= r.has_res;
    row_res <= r.res;
    in_held = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic lower_input();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
    end
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      lower_input();
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
    end
  endtask

  // hold the sender until every expected result has been taken, then let the block go idle
  task automatic settle();
    lower_input();
    @(posedge clk);
    while (due_dispatches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rqcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rqcd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    row_t   plan[$];
    phase_t phases[$];
    row_t   r;
    int     span;

    // after reset: arrival order, one core
    plan.push_back(ev_x(rqcd_pkg::MODE_ARRIVE, 5, 100, 0, 0, 1'b1, 0, 5));
    plan.push_back(ev_x(rqcd_pkg::MODE_ARRIVE, 127, 65535, 19, 31, 1'b0, 0, 0));
    plan.push_back(ev(rqcd_pkg::MODE_ARRIVE, 0, 0, -20, 17));
    plan.push_back(ev_x(rqcd_pkg::MODE_FINISH, 0, 0, 0, 0, 1'b1, 0, 127));
    plan.push_back(ev_x(rqcd_pkg::MODE_FINISH, 0, 0, 0, 31, 1'b0, 0, 0));  // idle, out of range
    plan.push_back(ev(rqcd_pkg::MODE_FINISH, 3, 7, 5, 0));
    plan.push_back(ev_x(rqcd_pkg::MODE_FINISH, 0, 0, 0, 0, 1'b0, 0, 0));   // nothing waiting
    plan.push_back(wr(rqcd_pkg::REG_POLICY, rqcd_pkg::POL_SJF));
    plan.push_back(ev_x(rqcd_pkg::MODE_ARRIVE, 10, 500, 3, 0, 1'b1, 0, 10));
    plan.push_back(ev(rqcd_pkg::MODE_ARRIVE, 11, 65535, -5, 0));
    plan.push_back(ev(rqcd_pkg::MODE_ARRIVE, 12, 0, 7, 0));
    plan.push_back(ev(rqcd_pkg::MODE_ARRIVE, 13, 0, -7, 0));     // equal length keeps order
    plan.push_back(ev(rqcd_pkg::MODE_FINISH, 0, 0, 0, 0));
    plan.push_back(ev(rqcd_pkg::MODE_FINISH, 0, 0, 0, 0));
    plan.push_back(wr(rqcd_pkg::REG_POLICY, rqcd_pkg::POL_PRIO));  // queued job keeps its place
    plan.push_back(ev(rqcd_pkg::MODE_ARRIVE, 20, 9, 19, 0));
    plan.push_back(ev(rqcd_pkg::MODE_ARRIVE, 21, 9, -20, 0));
    plan.push_back(ev(rqcd_pkg::MODE_ARRIVE, 22, 9, -1, 0));
    plan.push_back(ev(rqcd_pkg::MODE_FINISH, 0, 0, 0, 0));
    plan.push_back(wr(rqcd_pkg::REG_POLICY, POL_SPARE));
    plan.push_back(wr(rqcd_pkg::REG_CORE_COUNT, 0));
    plan.push_back(ev(rqcd_pkg::MODE_ARRIVE, 30, 1, 1, 0));
    plan.push_back(ev(rqcd_pkg::MODE_FINISH, 0, 0, 0, 0));
    plan.push_back(wr(rqcd_pkg::REG_POLICY, rqcd_pkg::POL_PRIO));
    plan.push_back(wr(rqcd_pkg::REG_CORE_COUNT, 63));
    plan.push_back(ev(rqcd_pkg::MODE_FINISH, 0, 0, 0, 5));       // raised count: one per event
    plan.push_back(ev(rqcd_pkg::MODE_ARRIVE, 40, 2, 0, 0));
    plan.push_back(wr(rqcd_pkg::REG_CORE_COUNT, 2));
    plan.push_back(ev(rqcd_pkg::MODE_FINISH, 0, 0, 0, 2));       // freed but above the count
    plan.push_back(ev(rqcd_pkg::MODE_FINISH, 0, 0, 0, 1));

    phases.push_back(phase_t'{POL_FCFS, 6'd4, 60, 55});
    phases.push_back(phase_t'{rqcd_pkg::POL_SJF, 6'd1, 170, 93});   // fills the queue, then drops
    phases.push_back(phase_t'{rqcd_pkg::POL_SJF, 6'd1, 130, 6});    // drains it
    phases.push_back(phase_t'{rqcd_pkg::POL_PRIO, 6'd3, 60, 50});
    phases.push_back(phase_t'{rqcd_pkg::POL_PRIO, 6'd32, 60, 60});
    phases.push_back(phase_t'{POL_SPARE, 6'd0, 40, 50});
    phases.push_back(phase_t'{POL_FCFS, 6'd63, 40, 50});
    phases.push_back(phase_t'{rqcd_pkg::POL_SJF, 6'd5, 40, 50});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i]);
        pace();
      end
    end

    foreach (phases[p]) begin
      settle();
      write_reg(rqcd_pkg::REG_POLICY, rqcd_pkg::CFG_DATA_W'(phases[p].pol));
      write_reg(rqcd_pkg::REG_CORE_COUNT, phases[p].cores);
      span = (phases[p].cores == 0) ? 1 :
             (phases[p].cores > rqcd_pkg::MAX_CORES) ? rqcd_pkg::MAX_CORES
                                                     : int'(phases[p].cores);
      for (int k = 0; k < phases[p].items; k++) begin
        if (p == 0 && k == phases[p].items / 2) settle();
        r = random_event(phases[p].arrive_pct, span);
        send_item(r);
        pace();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rqcd_pkg.sv
rtl/rqcd_cell.sv
rtl/rqcd_queue.sv
rtl/rqcd_cores.sv
rtl/ready_queue_core_dispatcher.sv
rtl/rqcd_checker.sv
test/ready_queue_core_dispatcher_tb.sv
